// ===== src/cnp_pkg.sv =====
// ----------------------------------------------------------------------------
// cnp_pkg: shared types and constants for the cellular noise pixel block
// Holds the fixed-point widths, hash constants, the form and register codes,
// and the structs that pass configuration and per-cell data between modules.
// ----------------------------------------------------------------------------
package cnp_pkg;

   // Fixed-point format of positions and distances.
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 17;
   localparam int SCALE_W    = 21;
   localparam int JIT_W      = 18;
   localparam int GAIN_W     = 19;
   localparam int CAP_W      = 17;
   localparam int SEED_W     = 32;
   localparam int OUT_W      = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Neighborhood and datapath widths.
   localparam int LANES      = 9;
   localparam int DIST_W     = 19;
   localparam int DSUM_W     = 20;
   localparam int SQ_W       = 40;
   localparam int ROOT_STEPS = 20;
   localparam int CV_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   // Hash and mixing multipliers.
   localparam logic [31:0] HASH_MUL_A    = 32'h9e3779b9;
   localparam logic [31:0] HASH_MUL_B    = 32'h85ebca6b;
   localparam logic [31:0] MIX_MUL_A     = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B     = 32'h846ca68b;
   localparam logic [31:0] SEED_OFS_Y    = 32'd31;
   localparam logic [31:0] SEED_OFS_CELL = 32'd71;

   // Value limits and blend weights.
   localparam logic [OUT_W-1:0]   ONE_Q     = 17'h10000;
   localparam logic [SCALE_W-1:0] SCALE_MIN = 21'd66;
   localparam logic [JIT_W-1:0]   JIT_MAX   = 18'd131072;
   localparam logic [CAP_W-1:0]   CAP_MAX   = 17'd65536;
   localparam logic [15:0]        LERP_KEEP = 16'd42598;
   localparam logic [15:0]        LERP_CELL = 16'd22938;

   typedef enum logic [2:0] {
      FORM_INV_F1, FORM_CELL, FORM_INV_F2, FORM_DIFF, FORM_CUBE, FORM_PRODUCT, FORM_LERP
   } cnp_form_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SCALE, CSR_JITTER, CSR_METRIC, CSR_FORM, CSR_GAIN, CSR_CAP, CSR_SEED
   } cnp_csr_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [JIT_W-1:0]   jitter;
      logic               manhattan;
      cnp_form_type       form;
      logic [GAIN_W-1:0]  gain;
      logic [CAP_W-1:0]   cap;
      logic [SEED_W-1:0]  seed;
   } cnp_cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] ax;
      logic [DIST_W-1:0] ay;
      logic [CV_W-1:0]   cv;
   } cnp_cell_type;

   typedef cnp_cell_type [LANES-1:0] cnp_cells_type;

endpackage

// ===== src/cnp_queue.sv =====
// ----------------------------------------------------------------------------
// cnp_queue: short queue between the front and back halves
// Holds per-cell offsets of up to four requests so each half stalls on its own.
// ----------------------------------------------------------------------------
module cnp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cnp_pkg::cnp_cells_type wdata,
   output logic                   full,
   input  logic                   pop,
   output cnp_pkg::cnp_cells_type rdata,
   output logic                   empty
);
   import cnp_pkg::*;

   cnp_cells_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ===== src/cnp_front.sv =====
// ----------------------------------------------------------------------------
// cnp_front: coordinate scaling, cell hashing and feature offsets
// Seven-stage pipeline that maps a pixel to cell space and works out, for each
// of the nine neighboring cells, the offset to its jittered feature point.
// ----------------------------------------------------------------------------
module cnp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  cnp_pkg::cnp_cfg_type                cfg,
   input  logic                                req_push,
   input  logic signed [cnp_pkg::COORD_W-1:0]  req_x_norm,
   input  logic signed [cnp_pkg::COORD_W-1:0]  req_y_norm,
   output logic                                req_full,
   output logic                                q_push,
   output cnp_pkg::cnp_cells_type              q_wdata,
   input  logic                                q_full
);
   import cnp_pkg::*;

   localparam int NF     = 7;
   localparam int PROD_W = 44;
   localparam int CELL_W = 12;
   localparam int OFS_W  = 20;
   localparam int REL_W  = 21;

   logic [NF-1:0] vld_ff;
   logic          adv;

   logic signed [COORD_W-1:0] x0_ff, y0_ff;
   logic [SCALE_W+4:0]        step_k;
   logic signed [PROD_W-1:0]  px_prod, py_prod;
   logic signed [CELL_W-1:0]  bx1_ff, by1_ff;
   logic [FRAC_BITS-1:0]      frx_ff [1:5];
   logic [FRAC_BITS-1:0]      fry_ff [1:5];
   logic [31:0]               xa_in [3], xb_in [3], ya_in [3], yb_in [3];
   logic [31:0]               xa_ff [3], xb_ff [3], ya_ff [3], yb_ff [3];
   logic [31:0]               m1_in [LANES][3], m1_ff [LANES][3];
   logic [31:0]               m2_in [LANES][3], m2_ff [LANES][3];
   logic signed [OFS_W-1:0]   ox_in [LANES], oy_in [LANES];
   logic signed [OFS_W-1:0]   ox_ff [LANES], oy_ff [LANES];
   logic [CV_W-1:0]           cv_in [LANES], cv_ff [LANES];
   cnp_cells_type             cells_in, cells_ff;

   // The whole pipeline moves unless a finished request waits on a full queue.
   assign adv      = !(vld_ff[NF-1] && q_full);
   assign req_full = !adv;
   assign q_push   = vld_ff[NF-1] && !q_full;
   assign q_wdata  = cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NF-2:0], req_push};
      end
   end

   // Scale by 18 times the scale setting; the upper bits give the cell index.
   assign step_k  = (SCALE_W+5)'({cfg.scale, 4'b0}) + (SCALE_W+5)'({cfg.scale, 1'b0});
   assign px_prod = PROD_W'(x0_ff) * PROD_W'($signed({1'b0, step_k}));
   assign py_prod = PROD_W'(y0_ff) * PROD_W'($signed({1'b0, step_k}));

   // Hash input products for the three column and three row indexes.
   always_comb begin
      logic signed [CELL_W:0] cxs, cys;
      logic [31:0]            cx32, cy32;
      for (int d = 0; d < 3; d++) begin
         cxs = (CELL_W+1)'(bx1_ff) + (CELL_W+1)'(d - 1);
         cys = (CELL_W+1)'(by1_ff) + (CELL_W+1)'(d - 1);
         cx32 = 32'(cxs);
         cy32 = 32'(cys);
         xa_in[d] = 32'(cx32 * HASH_MUL_A);
         xb_in[d] = 32'(cx32 * HASH_MUL_B);
         ya_in[d] = 32'(cy32 * HASH_MUL_A);
         yb_in[d] = 32'(cy32 * HASH_MUL_B);
      end
   end

   // Seed the three hashes of each cell and run both mixing rounds.
   always_comb begin
      logic [31:0] h [3];
      logic [31:0] t;
      for (int gy = 0; gy < 3; gy++) begin
         for (int gx = 0; gx < 3; gx++) begin
            h[0] = xa_ff[gx] ^ yb_ff[gy] ^ cfg.seed;
            h[1] = ya_ff[gy] ^ xb_ff[gx] ^ (cfg.seed + SEED_OFS_Y);
            h[2] = xa_ff[gx] ^ yb_ff[gy] ^ (cfg.seed + SEED_OFS_CELL);
            for (int j = 0; j < 3; j++) begin
               m1_in[gy*3+gx][j] = 32'((h[j] ^ (h[j] >> 16)) * MIX_MUL_A);
               t = m1_ff[gy*3+gx][j];
               m2_in[gy*3+gx][j] = 32'((t ^ (t >> 15)) * MIX_MUL_B);
            end
         end
      end
   end

   // Final mix, jitter scaling of the feature offset, and the cell value.
   always_comb begin
      logic [23:0]             hx, hy, hc;
      logic signed [24:0]      sx, sy;
      logic signed [PROD_W-1:0] jx, jy;
      for (int l = 0; l < LANES; l++) begin
         hx = 24'(m2_ff[l][0] ^ (m2_ff[l][0] >> 16));
         hy = 24'(m2_ff[l][1] ^ (m2_ff[l][1] >> 16));
         hc = 24'(m2_ff[l][2] ^ (m2_ff[l][2] >> 16));
         sx = $signed({1'b0, hx}) - 25'sh800000;
         sy = $signed({1'b0, hy}) - 25'sh800000;
         jx = PROD_W'(sx) * PROD_W'($signed({1'b0, cfg.jitter}));
         jy = PROD_W'(sy) * PROD_W'($signed({1'b0, cfg.jitter}));
         ox_in[l] = jx[PROD_W-1:40-FRAC_BITS];
         oy_in[l] = jy[PROD_W-1:40-FRAC_BITS];
         cv_in[l] = hc[23:24-CV_W];
      end
   end

   // Offset from the pixel to each feature point, taken as magnitudes.
   always_comb begin
      logic signed [REL_W-1:0] ofs_x, ofs_y, rx, ry;
      for (int gy = 0; gy < 3; gy++) begin
         for (int gx = 0; gx < 3; gx++) begin
            ofs_x = REL_W'(32768 - gx * 65536);
            ofs_y = REL_W'(32768 - gy * 65536);
            rx = $signed(REL_W'(frx_ff[5])) + ofs_x - REL_W'(ox_ff[gy*3+gx]);
            ry = $signed(REL_W'(fry_ff[5])) + ofs_y - REL_W'(oy_ff[gy*3+gx]);
            rx = rx[REL_W-1] ? -rx : rx;
            ry = ry[REL_W-1] ? -ry : ry;
            cells_in[gy*3+gx].ax = rx[DIST_W-1:0];
            cells_in[gy*3+gx].ay = ry[DIST_W-1:0];
            cells_in[gy*3+gx].cv = cv_ff[gy*3+gx];
         end
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff     <= req_x_norm;
         y0_ff     <= req_y_norm;
         bx1_ff    <= px_prod[PROD_W-1:32];
         by1_ff    <= py_prod[PROD_W-1:32];
         frx_ff[1] <= px_prod[31:32-FRAC_BITS];
         fry_ff[1] <= py_prod[31:32-FRAC_BITS];
         for (int s = 2; s <= 5; s++) begin
            frx_ff[s] <= frx_ff[s-1];
            fry_ff[s] <= fry_ff[s-1];
         end
         xa_ff    <= xa_in;
         xb_ff    <= xb_in;
         ya_ff    <= ya_in;
         yb_ff    <= yb_in;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         cv_ff    <= cv_in;
         cells_ff <= cells_in;
      end
   end

endmodule

// ===== src/cnp_back.sv =====
// ----------------------------------------------------------------------------
// cnp_back: distances, nearest-two search, form shaping and result queue
// Pipelined square root per lane, two-stage F1/F2 search in row order, then
// form selection, gain and cap into a four-entry result queue.
// ----------------------------------------------------------------------------
module cnp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cnp_pkg::cnp_cfg_type          cfg,
   input  cnp_pkg::cnp_cells_type        q_rdata,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [cnp_pkg::OUT_W-1:0]     rsp_height_value
);
   import cnp_pkg::*;

   localparam int NB     = ROOT_STEPS + 8;
   localparam int SORT_A = 5;

   logic [NB-1:0]       vld_ff;
   logic                adv;
   cnp_cells_type       c0_ff;
   logic [2*DIST_W-1:0] sqx_ff [LANES], sqy_ff [LANES];
   logic [DSUM_W-1:0]   man1_ff [LANES];
   logic [CV_W-1:0]     cv1_ff [LANES];
   logic [SQ_W-1:0]     n_ff [0:ROOT_STEPS][LANES];
   logic [SQ_W-1:0]     r_ff [0:ROOT_STEPS][LANES];
   logic [DSUM_W-1:0]   man_ff [0:ROOT_STEPS][LANES];
   logic [CV_W-1:0]     cvq_ff [0:ROOT_STEPS][LANES];
   logic [SQ_W-1:0]     n_in [ROOT_STEPS][LANES];
   logic [SQ_W-1:0]     r_in [ROOT_STEPS][LANES];
   logic [DSUM_W-1:0]   d_in [LANES], da_ff [LANES];
   logic [CV_W-1:0]     cva_ff [LANES];
   logic [DSUM_W-1:0]   f1a_in, f2a_in, f1a_ff, f2a_ff, f1_in, f2_in, f1_ff, f2_ff;
   logic [CV_W-1:0]     cvsa_in, cvsa_ff, cvs_in, cvs_ff;
   logic [OUT_W-1:0]    v1_in, v2_in, v3_in, v1_ff, v2_ff, v3_ff;
   logic [OUT_W-1:0]    sq_ff, pm_ff, v_in, v_ff;
   logic [CV_W-1:0]     cvp_ff;
   logic [33:0]         la_ff, lb_ff;
   logic [DSUM_W-1:0]   res_ff;
   logic [OUT_W-1:0]    capped;

   // Result queue state.
   logic [OUT_W-1:0]    of_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   of_wr_ff, of_rd_ff;
   logic [QPTR_W:0]     of_cnt_ff;
   logic                of_full, of_push, of_pop;

   assign of_full = (of_cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign adv     = !(vld_ff[NB-1] && of_full);
   assign q_pop   = adv && !q_empty;
   assign of_push = vld_ff[NB-1] && !of_full;
   assign of_pop  = rsp_pop && !rsp_empty;
   assign rsp_empty        = (of_cnt_ff == '0);
   assign rsp_height_value = of_mem_ff[of_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NB-2:0], !q_empty};
      end
   end

   // One restoring square root digit per stage and lane.
   always_comb begin
      logic [SQ_W-1:0] b, t;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         for (int l = 0; l < LANES; l++) begin
            b = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
            t = r_ff[k][l] + b;
            if (n_ff[k][l] >= t) begin
               n_in[k][l] = n_ff[k][l] - t;
               r_in[k][l] = (r_ff[k][l] >> 1) + b;
            end else begin
               n_in[k][l] = n_ff[k][l];
               r_in[k][l] = r_ff[k][l] >> 1;
            end
         end
      end
   end

   // Metric choice, then the nearest-two search over the first five cells.
   always_comb begin
      logic [DSUM_W-1:0] f1, f2;
      logic [CV_W-1:0]   cv;
      f1 = '1;
      f2 = '1;
      cv = '0;
      for (int l = 0; l < LANES; l++) begin
         d_in[l] = cfg.manhattan ? man_ff[ROOT_STEPS][l] : r_ff[ROOT_STEPS][l][DSUM_W-1:0];
      end
      for (int l = 0; l < SORT_A; l++) begin
         if (d_in[l] < f1) begin
            f2 = f1;
            f1 = d_in[l];
            cv = cvq_ff[ROOT_STEPS][l];
         end else if (d_in[l] < f2) begin
            f2 = d_in[l];
         end
      end
      f1a_in  = f1;
      f2a_in  = f2;
      cvsa_in = cv;
   end

   // The remaining four cells.
   always_comb begin
      logic [DSUM_W-1:0] f1, f2;
      logic [CV_W-1:0]   cv;
      f1 = f1a_ff;
      f2 = f2a_ff;
      cv = cvsa_ff;
      for (int l = SORT_A; l < LANES; l++) begin
         if (da_ff[l] < f1) begin
            f2 = f1;
            f1 = da_ff[l];
            cv = cva_ff[l];
         end else if (da_ff[l] < f2) begin
            f2 = da_ff[l];
         end
      end
      f1_in  = f1;
      f2_in  = f2;
      cvs_in = cv;
   end

   // Inverted and difference terms, each limited to one.
   always_comb begin
      logic [DSUM_W-1:0] diff;
      diff  = f2_ff - f1_ff;
      v1_in = ONE_Q - ((f1_ff > DSUM_W'(ONE_Q)) ? ONE_Q : f1_ff[OUT_W-1:0]);
      v2_in = ONE_Q - ((f2_ff > DSUM_W'(ONE_Q)) ? ONE_Q : f2_ff[OUT_W-1:0]);
      v3_in = (diff > DSUM_W'(ONE_Q)) ? ONE_Q : diff[OUT_W-1:0];
   end

   // Form selection; an unused code falls back to inverted F1.
   always_comb begin
      logic [33:0] cube;
      logic [34:0] lerp;
      cube = (34'(sq_ff) * 34'(v1_ff)) >> FRAC_BITS;
      lerp = (35'(la_ff) + 35'(lb_ff)) >> 16;
      unique case (cfg.form)
         FORM_INV_F1:  v_in = v1_ff;
         FORM_CELL:    v_in = OUT_W'(cvp_ff);
         FORM_INV_F2:  v_in = v2_ff;
         FORM_DIFF:    v_in = v3_ff;
         FORM_CUBE:    v_in = cube[OUT_W-1:0];
         FORM_PRODUCT: v_in = pm_ff;
         FORM_LERP:    v_in = lerp[OUT_W-1:0];
         default:      v_in = v1_ff;
      endcase
   end

   assign capped = (res_ff > DSUM_W'(cfg.cap)) ? cfg.cap : res_ff[OUT_W-1:0];

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         c0_ff <= q_rdata;
         for (int l = 0; l < LANES; l++) begin
            sqx_ff[l]        <= (2*DIST_W)'(c0_ff[l].ax) * (2*DIST_W)'(c0_ff[l].ax);
            sqy_ff[l]        <= (2*DIST_W)'(c0_ff[l].ay) * (2*DIST_W)'(c0_ff[l].ay);
            man1_ff[l]       <= DSUM_W'(c0_ff[l].ax) + DSUM_W'(c0_ff[l].ay);
            cv1_ff[l]        <= c0_ff[l].cv;
            n_ff[0][l]       <= SQ_W'(sqx_ff[l]) + SQ_W'(sqy_ff[l]);
            r_ff[0][l]       <= '0;
            man_ff[0][l]     <= man1_ff[l];
            cvq_ff[0][l]     <= cv1_ff[l];
            for (int k = 0; k < ROOT_STEPS; k++) begin
               n_ff[k+1][l]   <= n_in[k][l];
               r_ff[k+1][l]   <= r_in[k][l];
               man_ff[k+1][l] <= man_ff[k][l];
               cvq_ff[k+1][l] <= cvq_ff[k][l];
            end
            da_ff[l]  <= d_in[l];
            cva_ff[l] <= cvq_ff[ROOT_STEPS][l];
         end
         f1a_ff  <= f1a_in;
         f2a_ff  <= f2a_in;
         cvsa_ff <= cvsa_in;
         f1_ff   <= f1_in;
         f2_ff   <= f2_in;
         cvs_ff  <= cvs_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         cvp_ff  <= cvs_ff;
         sq_ff   <= OUT_W'((34'(v1_in) * 34'(v1_in)) >> FRAC_BITS);
         pm_ff   <= OUT_W'((34'(v1_in) * 34'(cvs_ff)) >> FRAC_BITS);
         la_ff   <= 34'(v1_in) * 34'(LERP_KEEP);
         lb_ff   <= 34'(cvs_ff) * 34'(LERP_CELL);
         v_ff    <= v_in;
         res_ff  <= DSUM_W'((36'(v_ff) * 36'(cfg.gain)) >> FRAC_BITS);
      end
   end

   // Result queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         of_wr_ff  <= '0;
         of_rd_ff  <= '0;
         of_cnt_ff <= '0;
      end else begin
         if (of_push) begin
            of_wr_ff <= of_wr_ff + 1'b1;
         end
         if (of_pop) begin
            of_rd_ff <= of_rd_ff + 1'b1;
         end
         of_cnt_ff <= of_cnt_ff + (QPTR_W+1)'(of_push) - (QPTR_W+1)'(of_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (of_push) begin
         of_mem_ff[of_wr_ff] <= capped;
      end
   end

endmodule

// ===== src/cellular_noise_pixel.sv =====
// ----------------------------------------------------------------------------
// cellular_noise_pixel: 3x3 cellular noise height for one pixel per request
// Configuration registers, the hashing front half, the request queue and the
// distance and shaping back half.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  request   req_push / req_full   req_x_norm, req_y_norm (17 b signed Q.16)
//  result    rsp_pop / rsp_empty   rsp_height_value (17 b unsigned Q.16)
//  config    csr_we                csr_addr, csr_wdata
//
// One request is taken per cycle while req_full is low; a request passes
// through the front pipeline, the middle queue, the 20 square root digit
// stages and the shaping stages of the back half.
// Reset clears the queues and pipelines and loads the register defaults.
// A full result queue stalls the back half; a full middle queue stalls the
// front half, which raises req_full.
// ----------------------------------------------------------------------------
module cellular_noise_pixel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [cnp_pkg::COORD_W-1:0]  req_x_norm,
   input  logic signed [cnp_pkg::COORD_W-1:0]  req_y_norm,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [cnp_pkg::OUT_W-1:0]           rsp_height_value,
   input  logic                                csr_we,
   input  logic [cnp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [cnp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cnp_pkg::*;

   logic [SCALE_W-1:0] scale_ff;
   logic [JIT_W-1:0]   jitter_ff;
   logic               metric_ff;
   logic [2:0]         form_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [SEED_W-1:0]  seed_ff;
   cnp_cfg_type        cfg;
   logic               q_push, q_full, q_pop, q_empty;
   cnp_cells_type      q_wdata, q_rdata;

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_W'(65536);
         jitter_ff <= JIT_W'(65536);
         metric_ff <= 1'b0;
         form_ff   <= 3'(FORM_INV_F1);
         gain_ff   <= GAIN_W'(65536);
         cap_ff    <= CAP_W'(65536);
         seed_ff   <= SEED_W'(1337);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SCALE:  scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_JITTER: jitter_ff <= csr_wdata[JIT_W-1:0];
            CSR_METRIC: metric_ff <= csr_wdata[0];
            CSR_FORM:   form_ff   <= csr_wdata[2:0];
            CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_CAP:    cap_ff    <= csr_wdata[CAP_W-1:0];
            CSR_SEED:   seed_ff   <= csr_wdata[SEED_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective settings with their range limits applied.
   always_comb begin
      cfg.scale     = (scale_ff < SCALE_MIN) ? SCALE_MIN : scale_ff;
      cfg.jitter    = (jitter_ff > JIT_MAX) ? JIT_MAX : jitter_ff;
      cfg.manhattan = metric_ff;
      cfg.form      = cnp_form_type'(form_ff);
      cfg.gain      = gain_ff;
      cfg.cap       = (cap_ff > CAP_MAX) ? CAP_MAX : cap_ff;
      cfg.seed      = seed_ff;
   end

   cnp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_push   (req_push),
      .req_x_norm (req_x_norm),
      .req_y_norm (req_y_norm),
      .req_full   (req_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_full     (q_full)
   );

   cnp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   cnp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_rdata          (q_rdata),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_height_value (rsp_height_value)
   );

endmodule

// ===== src/cnp_checker.sv =====
// ----------------------------------------------------------------------------
// cnp_checker: port-level checks for the cellular noise pixel block
// Tracks requests in flight and checks that results have a request behind them, stay in range and are held.
// ----------------------------------------------------------------------------
module cnp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic [cnp_pkg::OUT_W-1:0]           rsp_height_value
);
   import cnp_pkg::*;

   logic [7:0] pend_ff;
   logic       in_acc, out_acc;

   assign in_acc  = req_push && !req_full;
   assign out_acc = rsp_pop && !rsp_empty;

   // Requests accepted but not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 8'(in_acc) - 8'(out_acc);
      end
   end

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> pend_ff != '0)
      else $error("result shown with no request outstanding");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_height_value <= ONE_Q)
      else $error("height above one");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_height_value))
      else $error("waiting result changed or vanished");

endmodule

bind cellular_noise_pixel cnp_checker u_checker (.*);

// ===== sim/cellular_noise_pixel_test.sv =====
// ----------------------------------------------------------------------------
// cellular_noise_pixel_test: self-checking bench for the cellular noise block
// A queue-fed driver pushes pixel coordinates, and a monitor pops heights and
// compares each one with a height worked out by an in-bench predictor.
// Phases cover every form and register extreme, then random configurations.
// Both sides idle at random, and the monitor holds off once to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cellular_noise_pixel_test;
   import cnp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [2:0]            FORM_SPARE = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 48;
   // The hold starts once the directed forms and the first phase are done,
   // so the next phase keeps offering requests into a blocked result side.
   localparam int HOLD_AFTER     = 82;
   localparam int HOLD_CYCLES    = 300;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } pixel_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic signed [COORD_W-1:0]   req_x_norm = '0;
   logic signed [COORD_W-1:0]   req_y_norm = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [OUT_W-1:0]            rsp_height_value;
   logic                        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_addr = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   // Bench copy of the configuration registers.
   logic [SCALE_W-1:0] scale_reg  = 21'd65536;
   logic [JIT_W-1:0]   jitter_reg = 18'd65536;
   logic               metric_reg = 1'b0;
   logic [2:0]         form_reg   = 3'd0;
   logic [GAIN_W-1:0]  gain_reg   = 19'd65536;
   logic [CAP_W-1:0]   cap_reg    = 17'd65536;
   logic [SEED_W-1:0]  seed_reg   = 32'd1337;

   pixel_type          pixel_queue[$];
   logic [OUT_W-1:0]   height_queue[$];
   bit                 quiet = 1'b0;
   bit                 failed = 1'b0;
   int                 heights_seen = 0;
   int                 hold_left = 0;
   int                 stall_cycles = 0;

   cellular_noise_pixel DUT (.*);

   always #2 clock = ~clock;

   // Integer hash of a cell pair, kept to 24 bits.
   function automatic logic [31:0] cell_hash(longint a, longint b, logic [31:0] s);
      logic [31:0] h;
      h = (a[31:0] * HASH_MUL_A) ^ (b[31:0] * HASH_MUL_B) ^ s;
      h = h ^ (h >> 16);
      h = h * MIX_MUL_A;
      h = h ^ (h >> 15);
      h = h * MIX_MUL_B;
      h = h ^ (h >> 16);
      return h & 32'h00ffffff;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Height of one pixel under the current bench configuration.
   function automatic logic [OUT_W-1:0] predict_height(logic signed [COORD_W-1:0] x,
                                                       logic signed [COORD_W-1:0] y);
      longint sc, jt, px, py, bx, by, cx, cy, hx, hy, fx, fy, v, cv, res, cap, one;
      longint unsigned f1, f2, ax, ay, d;
      one = 64'sd65536;
      sc = (scale_reg < SCALE_MIN) ? 66 : longint'(scale_reg);
      jt = (jitter_reg > JIT_MAX) ? 131072 : longint'(jitter_reg);
      px = (longint'(x) * 18 * sc) >>> 16;
      py = (longint'(y) * 18 * sc) >>> 16;
      bx = px >>> FRAC_BITS;
      by = py >>> FRAC_BITS;
      f1 = '1;
      f2 = '1;
      cv = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            cx = bx + dx;
            cy = by + dy;
            hx = longint'(cell_hash(cx, cy, seed_reg)) - 64'sh800000;
            hy = longint'(cell_hash(cy, cx, seed_reg + SEED_OFS_Y)) - 64'sh800000;
            fx = cx * one + one / 2 + ((hx * jt) >>> 24);
            fy = cy * one + one / 2 + ((hy * jt) >>> 24);
            ax = (px < fx) ? fx - px : px - fx;
            ay = (py < fy) ? fy - py : py - fy;
            d = metric_reg ? ax + ay : int_sqrt(ax * ax + ay * ay);
            if (d < f1) begin
               f2 = f1;
               f1 = d;
               cv = longint'(cell_hash(cx, cy, seed_reg + SEED_OFS_CELL) >> 8);
            end else if (d < f2) begin
               f2 = d;
            end
         end
      end
      v = one - ((f1 > 65536) ? one : longint'(f1));
      case (form_reg)
         FORM_CELL:    v = cv;
         FORM_INV_F2:  v = one - ((f2 > 65536) ? one : longint'(f2));
         FORM_DIFF:    v = ((f2 - f1) > 65536) ? one : longint'(f2 - f1);
         FORM_CUBE:    v = (((v * v) >>> FRAC_BITS) * v) >>> FRAC_BITS;
         FORM_PRODUCT: v = (v * cv) >>> FRAC_BITS;
         FORM_LERP:    v = (v * LERP_KEEP + cv * LERP_CELL) >>> 16;
         default:      v = v;
      endcase
      res = (v * longint'(gain_reg)) >>> FRAC_BITS;
      cap = (cap_reg > CAP_MAX) ? 65536 : longint'(cap_reg);
      if (res > cap) res = cap;
      return res[OUT_W-1:0];
   endfunction

   // Driver: predicts each accepted request and offers the next pending one.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (req_push)
            height_queue.push_back(predict_height(req_x_norm, req_y_norm));
         if (pixel_queue.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
            req_push   <= 1'b1;
            req_x_norm <= pixel_queue[0].x;
            req_y_norm <= pixel_queue[0].y;
            void'(pixel_queue.pop_front());
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: checks each popped height; holds off once ahead of a busy phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (height_queue.size() == 0) begin
               $error("unexpected height_value %0d", rsp_height_value);
               failed = 1'b1;
            end else begin
               if (rsp_height_value !== height_queue[0]) begin
                  $error("height_value expected %0d actual %0d",
                         height_queue[0], rsp_height_value);
                  failed = 1'b1;
               end
               void'(height_queue.pop_front());
            end
            heights_seen++;
            if (heights_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= quiet || $urandom_range(99) >= 7;
         end
      end
   end

   // Watchdog on cycles with no request or result accepted.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("cellular_noise_pixel_test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      case (index)
         CSR_SCALE:  scale_reg  = value[SCALE_W-1:0];
         CSR_JITTER: jitter_reg = value[JIT_W-1:0];
         CSR_METRIC: metric_reg = value[0];
         CSR_FORM:   form_reg   = value[2:0];
         CSR_GAIN:   gain_reg   = value[GAIN_W-1:0];
         CSR_CAP:    cap_reg    = value[CAP_W-1:0];
         CSR_SEED:   seed_reg   = value;
         default:    ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_push || height_queue.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(int x, int y);
      pixel_type p;
      p.x = x;
      p.y = y;
      pixel_queue.push_back(p);
   endtask

   task automatic add_random_pixels(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 7)
            add_pixel($urandom_range(65536) - 32768, $urandom_range(65536) - 32768);
         else
            add_pixel($urandom, $urandom);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: every form code with extreme and out-of-range coordinates.
      write_reg(CSR_SCALE, 32'd65536);
      write_reg(CSR_JITTER, 32'd65536);
      write_reg(CSR_METRIC, 32'd0);
      write_reg(CSR_GAIN, 32'd65536);
      write_reg(CSR_CAP, 32'd65536);
      write_reg(CSR_SEED, 32'd1337);
      write_reg(CSR_UNUSED, 32'hffffffff);
      for (int f = 0; f < 8; f++) begin
         write_reg(CSR_FORM, f);
         add_pixel(-32768, 32768);
         add_pixel(f[0] ? 65535 : -65536, f[1] ? 0 : -1);
         add_pixel(f * 4099, -f * 3001);
         wait_idle();
      end

      // Register extremes, then random settings; one phase runs without idling.
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_SCALE, 32'd66);  write_reg(CSR_JITTER, 32'd0);
               write_reg(CSR_GAIN, 32'd262144); write_reg(CSR_CAP, 32'd0);
            end
            1: begin
               write_reg(CSR_SCALE, 32'd1048576); write_reg(CSR_JITTER, 32'd131072);
               write_reg(CSR_GAIN, 32'd0); write_reg(CSR_CAP, 32'd131071);
            end
            2: begin
               write_reg(CSR_SCALE, 32'd0); write_reg(CSR_JITTER, 32'd262143);
               write_reg(CSR_GAIN, 32'd524287); write_reg(CSR_CAP, 32'd65536);
            end
            3: begin
               write_reg(CSR_SCALE, 32'h1fffff); write_reg(CSR_JITTER, 32'd131072);
               write_reg(CSR_GAIN, 32'd262144); write_reg(CSR_CAP, 32'd40000);
            end
            default: begin
               write_reg(CSR_SCALE, $urandom_range(1048576, 66));
               write_reg(CSR_JITTER, $urandom_range(131072));
               write_reg(CSR_GAIN, $urandom_range(262144));
               write_reg(CSR_CAP, $urandom_range(65536));
            end
         endcase
         write_reg(CSR_METRIC, $urandom_range(1));
         write_reg(CSR_FORM, (ph < 8) ? ph : $urandom_range(6));
         write_reg(CSR_SEED, ph == 0 ? 32'h80000000 : (ph == 1 ? 32'h7fffffff : $urandom));
         quiet = (ph == 5);
         add_random_pixels(58);
         wait_idle();
      end
      quiet = 1'b0;
      write_reg(CSR_FORM, FORM_SPARE);
      add_random_pixels(5);
      wait_idle();

      if (!failed)
         $display("cellular_noise_pixel_test passed");
      else
         $display("cellular_noise_pixel_test failed");
      $finish;
   end

endmodule
